FILE: sv/window_despike_filter_3x3_assert.svh
// Assertion macros for the despike filter; clk and arst_n are taken from the enclosing scope.
`ifndef WINDOW_DESPIKE_FILTER_3X3_ASSERT_SVH
`define WINDOW_DESPIKE_FILTER_3X3_ASSERT_SVH

// Condition and consequence in the same cycle.
`define WDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define WDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/wdf_pkg.sv
`timescale 1ns / 1ps
package wdf_pkg;
	localparam int PIX_W     = 16;
	localparam int MAX_WIDTH = 2048;
	localparam int MIN_WIDTH = 3;
	localparam int CFG_W     = 16;
	localparam int IMG_W     = 12;
	localparam int WIN_CELLS = 9;
	// mean rounding divide: numerator 2|rest|+m, denominator 2m
	localparam int DIV_W     = 20;
	localparam int DEN_W     = 5;

	typedef enum logic [1:0] {
		REG_REPLACE_MODE = 2'd0,
		REG_SIGMA_FACTOR = 2'd1,
		REG_TOLERANCE    = 2'd2,
		REG_IMAGE_WIDTH  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                    ok;
		logic signed [PIX_W-1:0] v;
	} cell_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage

FILE: sv/wdf_ram.sv
`timescale 1ns / 1ps
module wdf_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/wdf_div.sv
`timescale 1ns / 1ps
module wdf_div import wdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DIV_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_sts_t         sts,
	output logic [DIV_W-1:0] quot
);
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] work_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             qbit;
	logic [DEN_W:0]   rem_sub;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh  = {rem_q, work_q[DIV_W-1]};
		qbit    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q <= num;
			den_q  <= den;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], qbit};
			rem_q  <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = work_q;
endmodule

FILE: sv/window_despike_filter_3x3.sv
`timescale 1ns / 1ps
// 3x3 despike (sigma) filter over a raster pixel stream. Pixels come in one beat at a time in
// raster order with a valid flag standing for not-a-number; each result beat belongs to the
// pixel image_width+1 positions back, and pad beats below the last row flush the final row.
// The block takes one pixel at a time: a pixel that yields no result (start of frame, or deep
// in a pad run) passes only the line-store access, an invalid centre then goes to the output,
// a normal centre first passes the sweep and spike test, and a spike replaced by the mean also
// the divider. The line-store access reads, then writes back in the following cycle; the sweep
// over the nine window cells accumulates count, sum and square sum through one 16x16
// multiplier; the chain of seven narrow multiply steps forms the exact cross-multiplied spike
// test; and the bit-serial divider gives the rounded mean. The result sits in an output
// register, so a new pixel is taken while the previous result waits on res_stall. Line stores
// need no clearing after reset. Write configuration only while the block is idle.
module window_despike_filter_3x3 import wdf_pkg::*; #(
	parameter int MAX_WIDTH_P = MAX_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// pixel beats in
	input  logic                    pix_valid,
	output logic                    pix_stall,
	input  logic signed [PIX_W-1:0] pixel_value,
	input  logic                    pixel_valid,
	input  logic                    pad_item,
	input  logic                    frame_start,
	// result beats out
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [PIX_W-1:0] out_value,
	output logic                    out_valid,
	output logic                    spike_found,
	output logic                    row_last,
	// configuration writes
	input  logic                    wr_en,
	input  reg_idx_t                wr_index,
	input  logic [CFG_W-1:0]        wr_data
);
	`include "window_despike_filter_3x3_assert.svh"

	localparam int COL_W = $clog2(MAX_WIDTH_P);
	localparam int WID_W = $clog2(MAX_WIDTH_P + 1);
	localparam int CMP_W = (WID_W > IMG_W) ? WID_W : IMG_W;
	localparam int ROW_W = 16;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_READ = 14'b00000000000010,
		ST_ACC  = 14'b00000000000100,
		ST_P1   = 14'b00000000001000,
		ST_P2   = 14'b00000000010000,
		ST_P3   = 14'b00000000100000,
		ST_P4   = 14'b00000001000000,
		ST_P5   = 14'b00000010000000,
		ST_P6   = 14'b00000100000000,
		ST_P7   = 14'b00001000000000,
		ST_CMP  = 14'b00010000000000,
		ST_DIV  = 14'b00100000000000,
		ST_EMIT = 14'b01000000000000,
		ST_SPARE = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic             replace_q;
	logic [7:0]       sigma_q;
	logic [15:0]      tol_q;
	logic [IMG_W-1:0] width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_q <= 1'b0;
			sigma_q   <= 8'd24;
			tol_q     <= 16'd50;
			width_q   <= IMG_W'(2048);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REPLACE_MODE: replace_q <= wr_data[0];
				REG_SIGMA_FACTOR: sigma_q   <= wr_data[7:0];
				REG_TOLERANCE:    tol_q     <= wr_data[15:0];
				REG_IMAGE_WIDTH:  width_q   <= wr_data[IMG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the row width to the supported range
	logic [CMP_W-1:0] width_ext;
	logic [WID_W-1:0] w_use;

	always_comb begin
		width_ext = CMP_W'(width_q);
		if (width_ext < CMP_W'(MIN_WIDTH)) begin
			w_use = WID_W'(MIN_WIDTH);
		end else if (width_ext > CMP_W'(MAX_WIDTH_P)) begin
			w_use = WID_W'(MAX_WIDTH_P);
		end else begin
			w_use = width_ext[WID_W-1:0];
		end
	end

	// raster position at the accepting edge
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0]      pad_run_q;
	logic             accept;
	logic [COL_W-1:0] c_acc;
	logic [ROW_W-1:0] r_acc;
	logic [15:0]      pr_base;
	logic [WID_W-1:0] col_nxt;

	assign pix_stall = (state_q != ST_IDLE);
	assign accept    = pix_valid && !pix_stall;

	always_comb begin
		c_acc   = frame_start ? '0 : col_q;
		r_acc   = frame_start ? '0 : row_q;
		pr_base = frame_start ? '0 : pad_run_q;
		col_nxt = WID_W'(c_acc) + WID_W'(1);
	end

	// item registers
	logic [COL_W-1:0]        c_s1;
	logic [ROW_W-1:0]        r_s1;
	logic signed [PIX_W-1:0] x_s1;
	logic                    ok_s1;

	// line stores
	cell_t top_rd, mid_rd;
	cell_t new_cell;
	logic  ram_we;

	assign new_cell = '{ok: ok_s1, v: x_s1};
	assign ram_we   = (state_q == ST_READ);

	wdf_ram #(.WIDTH($bits(cell_t)), .DEPTH(MAX_WIDTH_P)) u_upper (
		.clk  (clk),
		.we   (ram_we),
		.waddr(c_s1),
		.wdata(mid_rd),
		.raddr(c_acc),
		.rdata(top_rd)
	);

	wdf_ram #(.WIDTH($bits(cell_t)), .DEPTH(MAX_WIDTH_P)) u_middle (
		.clk  (clk),
		.we   (ram_we),
		.waddr(c_s1),
		.wdata(new_cell),
		.raddr(c_acc),
		.rdata(mid_rd)
	);

	// 3x3 window, column 2 is the newest
	cell_t win_q [3][3];

	// emit decision and border flags for the centre
	logic emit_ok;
	logic no_left, no_right, no_top;

	always_comb begin
		emit_ok  = ((r_s1 >= ROW_W'(2)) || ((r_s1 == ROW_W'(1)) && (c_s1 >= COL_W'(1))))
			&& !({1'b0, pad_run_q} > (17'(w_use) + 17'd1));
		no_left  = (c_s1 == COL_W'(1));
		no_right = (c_s1 == '0);
		no_top   = ((c_s1 != '0) && (r_s1 == ROW_W'(1)))
			|| ((c_s1 == '0) && (r_s1 == ROW_W'(2)));
	end

	logic no_left_q, no_right_q, no_top_q;

	// statistics
	logic [1:0]                 i_q, j_q;
	logic [3:0]                 n_q;
	logic signed [19:0]         s_q;
	logic [33:0]                q_q;
	cell_t                      cell_sel;
	logic                       incl;
	logic signed [2*PIX_W-1:0]  sq_w;

	always_comb begin
		cell_sel = win_q[i_q][j_q];
		incl     = cell_sel.ok && !((i_q == 2'd0) && no_top_q)
			&& !((j_q == 2'd0) && no_left_q) && !((j_q == 2'd2) && no_right_q);
		sq_w     = cell_sel.v * cell_sel.v;
	end

	// arithmetic steps
	logic [3:0]         m_raw;
	logic signed [PIX_W-1:0] x_ctr;
	logic signed [19:0] rest_w;
	logic signed [20:0] mx_w;
	logic signed [21:0] d_w;
	logic signed [39:0] s2_w;

	always_comb begin
		m_raw  = n_q - 4'd1;
		x_ctr  = win_q[1][1].v;
		rest_w = s_q - 20'(x_ctr);
		mx_w   = $signed({1'b0, m_raw}) * x_ctr;
		d_w    = (m_raw == '0) ? 22'(x_ctr) : (22'(mx_w) - 22'(rest_w));
		s2_w   = s_q * s_q;
	end

	logic [3:0]         m_q;
	logic               has_nb_q;
	logic signed [19:0] rest_q;
	logic signed [21:0] d_q;
	logic [36:0]        nq_q;
	logic [36:0]        s2_q;
	logic [15:0]        sf2_q;
	logic [36:0]        var_q;
	logic [19:0]        ad_q;
	logic [21:0]        k_q;
	logic [38:0]        ad2_q;
	logic               tol_hit_q;
	logic [63:0]        lhs_q;
	logic [41:0]        plo_q;
	logic [38:0]        phi_q;

	logic [6:0]  m2_w, n2_w;
	logic [21:0] ad_abs;
	logic [63:0] rhs_w;
	logic        spike_w;
	logic [18:0] rest_abs;

	always_comb begin
		m2_w     = 7'(m_q * m_q);
		n2_w     = 7'(n_q * n_q);
		ad_abs   = d_q[21] ? 22'(-d_q) : 22'(d_q);
		rhs_w    = (64'(phi_q) << 20) + 64'(plo_q);
		spike_w  = (lhs_q > rhs_w) && tol_hit_q;
		rest_abs = rest_q[19] ? 19'(-rest_q) : 19'(rest_q);
	end

	// rounded mean divider
	div_ctl_t         div_ctl;
	div_sts_t         div_sts;
	logic [DIV_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [DIV_W-1:0] div_quot;
	logic [DIV_W-1:0] mean_w;

	assign div_ctl.start = (state_q == ST_CMP) && spike_w && replace_q && has_nb_q;
	assign div_num       = DIV_W'({rest_abs, 1'b0}) + DIV_W'(m_q);
	assign div_den       = DEN_W'({m_q, 1'b0});
	assign mean_w        = rest_q[19] ? DIV_W'(-div_quot) : div_quot;

	wdf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.num   (div_num),
		.den   (div_den),
		.sts   (div_sts),
		.quot  (div_quot)
	);

	// pending result
	logic signed [PIX_W-1:0] rv_val_q;
	logic                    rv_ok_q;
	logic                    rv_spk_q;
	logic                    res_valid_q;
	logic                    out_free;

	assign out_free = !res_valid_q || !res_stall;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			pad_run_q   <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			// load a new result beat, or drop the one just taken
			if ((state_q == ST_EMIT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// advance the raster position
						if (col_nxt >= w_use) begin
							col_q <= '0;
							row_q <= (r_acc == '1) ? r_acc : r_acc + ROW_W'(1);
						end else begin
							col_q <= col_nxt[COL_W-1:0];
							row_q <= r_acc;
						end
						if (pad_item) begin
							pad_run_q <= (pr_base == '1) ? pr_base : pr_base + 16'd1;
						end else begin
							pad_run_q <= '0;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// shift the window, newest column from the stores and the new pixel
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= top_rd;
					win_q[1][2] <= mid_rd;
					win_q[2][2] <= new_cell;
					if (!emit_ok) begin
						state_q <= ST_IDLE;
					end else if (!win_q[1][2].ok) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if ((i_q == 2'd2) && (j_q == 2'd2)) begin
						state_q <= ST_P1;
					end
				end
				ST_P1:  state_q <= ST_P2;
				ST_P2:  state_q <= ST_P3;
				ST_P3:  state_q <= ST_P4;
				ST_P4:  state_q <= ST_P5;
				ST_P5:  state_q <= ST_P6;
				ST_P6:  state_q <= ST_P7;
				ST_P7:  state_q <= ST_CMP;
				ST_CMP: state_q <= div_ctl.start ? ST_DIV : ST_EMIT;
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				c_s1  <= c_acc;
				r_s1  <= r_acc;
				x_s1  <= pixel_value;
				ok_s1 <= pixel_valid && !pad_item;
			end
			ST_READ: begin
				no_left_q  <= no_left;
				no_right_q <= no_right;
				no_top_q   <= no_top;
				i_q        <= 2'd0;
				j_q        <= 2'd0;
				n_q        <= '0;
				s_q        <= '0;
				q_q        <= '0;
				// an invalid centre gives an invalid result
				rv_val_q   <= '0;
				rv_ok_q    <= 1'b0;
				rv_spk_q   <= 1'b0;
			end
			ST_ACC: begin
				if (incl) begin
					n_q <= n_q + 4'd1;
					s_q <= s_q + 20'(cell_sel.v);
					q_q <= q_q + 34'(sq_w[2*PIX_W-2:0]);
				end
				if (j_q == 2'd2) begin
					j_q <= 2'd0;
					i_q <= i_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
			ST_P1: begin
				nq_q     <= 37'(n_q * q_q);
				d_q      <= d_w;
				rest_q   <= rest_w;
				m_q      <= (m_raw == '0) ? 4'd1 : m_raw;
				has_nb_q <= (m_raw != '0);
			end
			ST_P2: begin
				s2_q  <= s2_w[36:0];
				sf2_q <= sigma_q * sigma_q;
			end
			ST_P3: begin
				var_q <= nq_q - s2_q;
				ad_q  <= ad_abs[19:0];
				k_q   <= 22'(sf2_q * m2_w);
			end
			ST_P4: begin
				ad2_q     <= 39'(ad_q * ad_q);
				tol_hit_q <= ad_q > 20'(tol_q * m_q);
			end
			ST_P5: lhs_q <= 64'(ad2_q * n2_w) << 8;
			ST_P6: plo_q <= var_q[19:0] * k_q;
			ST_P7: phi_q <= var_q[36:20] * k_q;
			ST_CMP: begin
				rv_spk_q <= spike_w;
				if (!spike_w) begin
					rv_val_q <= win_q[1][1].v;
					rv_ok_q  <= 1'b1;
				end else begin
					// drop the spike, or take the mean (zero with no neighbour)
					rv_val_q <= '0;
					rv_ok_q  <= replace_q;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					rv_val_q <= mean_w[PIX_W-1:0];
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_value   <= rv_val_q;
					out_valid   <= rv_ok_q;
					spike_found <= rv_spk_q;
					row_last    <= no_right_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;

	`WDF_ASSERT_NEXT(a_accept_reads, accept, state_q == ST_READ, "accepted pixel did not read stores")
	`WDF_ASSERT_NOW(a_div_in_state, div_sts.busy, state_q == ST_DIV, "divider busy outside divide")
	`WDF_ASSERT_NOW(a_count_range, state_q == ST_P1, (n_q != 4'd0) && (n_q <= 4'(WIN_CELLS)),
		"valid cell count out of range")
	`WDF_ASSERT_NOW(a_var_nonneg, state_q == ST_P3, nq_q >= s2_q, "negative variance term")
endmodule
